// ===== rtl/dxt_pkg.sv =====
package dxt_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned PIXEL_W = 32;
    localparam int unsigned RGB_W   = 24;
    localparam int unsigned ROWS    = 4;
    localparam int unsigned COLS    = 4;

    typedef enum logic [1:0] {
        FMT_DXT1 = 2'd0,
        FMT_DXT3 = 2'd1,
        FMT_DXT5 = 2'd2
    } dxt_fmt_t;

    // Decoded block: both palettes plus the raw index bits still to be looked up
    typedef struct packed {
        logic [1:0]              fmt;
        logic [3:0][RGB_W-1:0]   color;
        logic [7:0][7:0]         alpha_pal;
        logic [WORD_W-1:0]       alpha_word;
        logic [31:0]             col_idx;
    } dxt_pal_t;

    typedef logic [COLS-1:0][PIXEL_W-1:0] dxt_row_t;

    // RGB565 to RGB888 by replicating the top bits into the bottom
    function automatic logic [RGB_W-1:0] widen565(input logic [15:0] c);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = c[15:11];
        g6 = c[10:5];
        b5 = c[4:0];
        return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
    endfunction

    // x / 6 for x < 1536, by reciprocal 683 / 4096
    function automatic logic [7:0] div6(input logic [10:0] x);
        logic [20:0] prod;
        prod = 21'(x) * 21'd683;
        return prod[19:12];
    endfunction

    // x / 14 for x < 3584, by reciprocal 2341 / 32768
    function automatic logic [7:0] div14(input logic [11:0] x);
        logic [23:0] prod;
        prod = 24'(x) * 24'd2341;
        return prod[22:15];
    endfunction

    // x / 10 for x < 2560, by reciprocal 1639 / 16384
    function automatic logic [7:0] div10(input logic [11:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'd1639;
        return prod[21:14];
    endfunction

    // (4*a + 2*b + 3) / 6 on one 8-bit channel
    function automatic logic [7:0] mix_third(input logic [7:0] a, input logic [7:0] b);
        logic [10:0] sum;
        sum = {1'b0, a, 2'b00} + {2'b00, b, 1'b0} + 11'd3;
        return div6(sum);
    endfunction

endpackage

// ===== rtl/dxt_in_if.sv =====
interface dxt_in_if;

    logic        valid;
    logic        ready;
    logic [63:0] alpha_word;
    logic [63:0] color_word;

    modport source (output valid, output alpha_word, output color_word, input ready);
    modport sink   (input valid, input alpha_word, input color_word, output ready);

endinterface

// ===== rtl/dxt_out_if.sv =====
interface dxt_out_if;

    logic        valid;
    logic        ready;
    logic [1:0]  row_index;
    logic [31:0] pixel_zero;
    logic [31:0] pixel_one;
    logic [31:0] pixel_two;
    logic [31:0] pixel_three;
    logic        last_row;

    modport source (output valid, output row_index, output pixel_zero, output pixel_one,
                    output pixel_two, output pixel_three, output last_row, input ready);
    modport sink   (input valid, input row_index, input pixel_zero, input pixel_one,
                    input pixel_two, input pixel_three, input last_row, output ready);

endinterface

// ===== rtl/dxt_block_decoder_top.sv =====
// S3TC block decoder. Each beat on block carries one compressed 4x4 block
// (alpha word and colour word); four beats follow on rows, one per pixel row
// from the top, each holding four RGBA8888 pixels left to right, with
// last_row set on the fourth. block_format selects DXT1, DXT3 or DXT5 (code 3
// decodes as DXT5); the user must write it through cfg_we/cfg_data only while
// idle, as the block itself does not enforce this. The block is three registers
// deep: an input register, a palette register and the row output register.
// The row sequencer on the palette register issues one row per cycle while
// rows.ready allows it. A new block is taken while the previous one is still
// sending rows.

module dxt_block_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data,
    dxt_in_if.sink     block,
    dxt_out_if.source  rows
);

    logic [1:0]            block_format_reg;

    // Input register
    logic                  s1_valid_reg;
    logic [63:0]           s1_alpha_reg;
    logic [63:0]           s1_color_reg;

    // Palette register and row sequencer
    logic                  s2_valid_reg;
    dxt_pkg::dxt_pal_t     s2_pal_reg;
    logic [1:0]            row_cnt_reg;
    logic [1:0]            row_cnt_next;

    // Row output register
    logic                  out_valid_reg;
    logic [1:0]            row_index_reg;
    dxt_pkg::dxt_row_t     pixels_reg;
    logic                  last_row_reg;

    dxt_pkg::dxt_pal_t     pal;
    dxt_pkg::dxt_row_t     pixels;

    logic                  out_free;
    logic                  row_issue;
    logic                  s2_free;
    logic                  s1_move;
    logic                  blk_take;

    // Handshake: each stage frees when the one below takes its beat
    assign out_free  = !out_valid_reg || rows.ready;
    assign row_issue = s2_valid_reg && out_free;
    assign s2_free   = !s2_valid_reg || (row_issue && (row_cnt_reg == 2'd3));
    assign s1_move   = s1_valid_reg && s2_free;
    assign block.ready = !s1_valid_reg || s2_free;
    assign blk_take  = block.valid && block.ready;
    assign row_cnt_next = row_cnt_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_format_reg <= dxt_pkg::FMT_DXT1;
        end
        else if (cfg_we)
        begin
            block_format_reg <= cfg_data;
        end
    end

    // Capture the incoming block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (block.ready)
        begin
            s1_valid_reg <= block.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_take)
        begin
            s1_alpha_reg <= block.alpha_word;
            s1_color_reg <= block.color_word;
        end
    end

    dxt_palette u_palette (
        .fmt        (block_format_reg),
        .alpha_word (s1_alpha_reg),
        .color_word (s1_color_reg),
        .pal        (pal)
    );

    // Hold the palette while its four rows go out; advance the row count per issue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            row_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (row_issue)
            begin
                row_cnt_reg <= row_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_pal_reg <= pal;
        end
    end

    dxt_row_mux u_row_mux (
        .pal    (s2_pal_reg),
        .row    (row_cnt_reg),
        .pixels (pixels)
    );

    // Row output register: load a new row, or drop the taken beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_issue)
        begin
            row_index_reg <= row_cnt_reg;
            pixels_reg    <= pixels;
            last_row_reg  <= (row_cnt_reg == 2'd3);
        end
    end

    assign rows.valid       = out_valid_reg;
    assign rows.row_index   = row_index_reg;
    assign rows.pixel_zero  = pixels_reg[0];
    assign rows.pixel_one   = pixels_reg[1];
    assign rows.pixel_two   = pixels_reg[2];
    assign rows.pixel_three = pixels_reg[3];
    assign rows.last_row    = last_row_reg;

    // A row beat ends its block exactly on the bottom row
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_row_reg == (row_index_reg == 2'd3)))
        else $error("last_row disagrees with row_index");

    // The row count stays at the top row while no palette is held
    a_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_valid_reg |-> (row_cnt_reg == 2'd0))
        else $error("row counter moved without a palette");

    // A taken row that is not the last is followed at once by the next row
    a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (rows.valid && rows.ready && !rows.last_row) |=>
            (rows.valid && (rows.row_index == $past(rows.row_index) + 2'd1)))
        else $error("row beats out of sequence");

    // Back-pressure on the input only while a block is held there
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !block.ready |-> (s1_valid_reg && s2_valid_reg))
        else $error("input stalled with room to spare");

endmodule

// ===== rtl/dxt_palette.sv =====
module dxt_palette (
    input  logic [1:0]     fmt,
    input  logic [63:0]    alpha_word,
    input  logic [63:0]    color_word,
    output dxt_pkg::dxt_pal_t pal
);

    logic [15:0] c0;
    logic [15:0] c1;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [23:0] e0;
    logic [23:0] e1;
    logic        three_mode;
    logic [8:0]  half_sum [3];
    logic [11:0] six_sum  [6];
    logic [11:0] four_sum [4];

    assign c0 = color_word[15:0];
    assign c1 = color_word[31:16];
    assign a0 = alpha_word[7:0];
    assign a1 = alpha_word[15:8];
    assign e0 = dxt_pkg::widen565(c0);
    assign e1 = dxt_pkg::widen565(c1);

    assign three_mode = (fmt == dxt_pkg::FMT_DXT1) && (c0 <= c1);

    always_comb
    begin
        pal            = '0;
        pal.fmt        = fmt;
        pal.alpha_word = alpha_word;
        pal.col_idx    = color_word[63:32];
        pal.color[0]   = e0;
        pal.color[1]   = e1;

        // Colour palette: channels are independent
        for (int ch = 0; ch < 3; ch++)
        begin
            half_sum[ch] = 9'(e0[ch*8 +: 8]) + 9'(e1[ch*8 +: 8]);
            if (three_mode)
            begin
                pal.color[2][ch*8 +: 8] = half_sum[ch][8:1];
                pal.color[3][ch*8 +: 8] = 8'd0;
            end
            else
            begin
                pal.color[2][ch*8 +: 8] = dxt_pkg::mix_third(e0[ch*8 +: 8], e1[ch*8 +: 8]);
                pal.color[3][ch*8 +: 8] = dxt_pkg::mix_third(e1[ch*8 +: 8], e0[ch*8 +: 8]);
            end
        end

        // Alpha palette: six interpolated steps, or four plus black and white
        pal.alpha_pal[0] = a0;
        pal.alpha_pal[1] = a1;
        for (int i = 0; i < 6; i++)
        begin
            six_sum[i] = 12'(12 - 2 * i) * 12'(a0) + 12'(2 + 2 * i) * 12'(a1) + 12'd7;
        end
        for (int i = 0; i < 4; i++)
        begin
            four_sum[i] = 12'(8 - 2 * i) * 12'(a0) + 12'(2 + 2 * i) * 12'(a1) + 12'd5;
        end
        if (a0 > a1)
        begin
            for (int i = 0; i < 6; i++)
            begin
                pal.alpha_pal[2 + i] = dxt_pkg::div14(six_sum[i]);
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                pal.alpha_pal[2 + i] = dxt_pkg::div10(four_sum[i]);
            end
            pal.alpha_pal[6] = 8'd0;
            pal.alpha_pal[7] = 8'd255;
        end
    end

endmodule

// ===== rtl/dxt_row_mux.sv =====
module dxt_row_mux (
    input  dxt_pkg::dxt_pal_t pal,
    input  logic [1:0]        row,
    output dxt_pkg::dxt_row_t pixels
);

    logic [3:0] pix   [4];
    logic [1:0] ci    [4];
    logic [3:0] nib   [4];
    logic [2:0] ai    [4];
    logic [7:0] alpha [4];

    always_comb
    begin
        for (int col = 0; col < 4; col++)
        begin
            pix[col] = {row, 2'(col)};
            ci[col]  = pal.col_idx[{pix[col], 1'b0} +: 2];
            nib[col] = pal.alpha_word[{pix[col], 2'b00} +: 4];
            ai[col]  = pal.alpha_word[6'd16 + 6'(pix[col]) * 6'd3 +: 3];
            case (pal.fmt)
                dxt_pkg::FMT_DXT1: alpha[col] = 8'd255;
                dxt_pkg::FMT_DXT3: alpha[col] = {nib[col], nib[col]};
                default:           alpha[col] = pal.alpha_pal[ai[col]];
            endcase
            pixels[col] = {pal.color[ci[col]], alpha[col]};
        end
    end

endmodule
